@@ hw/rtl/uffx_pkg.sv @@
`default_nettype none

package uffx_pkg;

   localparam logic [7:0] START_BYTE   = 8'h02;
   localparam logic [7:0] TYPE_REPLY   = 8'h80;
   localparam logic [7:0] TYPE_COMMAND = 8'h81;
   localparam logic [7:0] COUNT_MAX    = 8'hFF;

   localparam int unsigned RSP_DATA_BITS = 40;

   // one-hot parser phase
   typedef enum logic [5:0] {
      PH_HUNT = 6'b000001,
      PH_TYPE = 6'b000010,
      PH_CMD  = 6'b000100,
      PH_LEN  = 6'b001000,
      PH_DATA = 6'b010000,
      PH_SUM  = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] running_xor;
      logic [7:0] command;
      logic [7:0] length;
      logic [7:0] count;
      logic       kind;
   } parse_state_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       frame_done;
      logic       checksum_ok;
      logic       frame_kind;
      logic [7:0] command_code;
      logic [7:0] payload_length;
      logic       sync_lost;
   } parse_result_type;

endpackage

`default_nettype wire

@@ hw/rtl/uffx_step.sv @@
`default_nettype none

module uffx_step (
   input  wire uffx_pkg::parse_state_type cur_state,
   input  wire logic [7:0]                rx_byte,
   output uffx_pkg::parse_state_type      nxt_state,
   output uffx_pkg::parse_result_type     result
);
   import uffx_pkg::*;

   logic [7:0] count_inc;

   assign count_inc = (cur_state.count < COUNT_MAX) ? cur_state.count + 8'd1 : cur_state.count;

   always_comb begin
      nxt_state = cur_state;
      result.payload_valid = 1'b0;
      result.payload_byte  = '0;
      result.payload_index = '0;
      result.frame_done    = 1'b0;
      result.checksum_ok   = 1'b0;
      result.sync_lost     = 1'b0;

      unique case (cur_state.phase)
         PH_TYPE: begin
            if (rx_byte == START_BYTE) begin
               nxt_state.phase = PH_TYPE;
            end else if (rx_byte == TYPE_REPLY || rx_byte == TYPE_COMMAND) begin
               nxt_state.running_xor = rx_byte;
               nxt_state.kind        = (rx_byte == TYPE_COMMAND);
               nxt_state.phase       = PH_CMD;
            end else begin
               result.sync_lost = 1'b1;
               nxt_state.phase  = PH_HUNT;
            end
         end
         PH_CMD: begin
            nxt_state.command     = rx_byte;
            nxt_state.running_xor = cur_state.running_xor ^ rx_byte;
            nxt_state.phase       = PH_LEN;
         end
         PH_LEN: begin
            nxt_state.length      = rx_byte;
            nxt_state.running_xor = cur_state.running_xor ^ rx_byte;
            nxt_state.count       = '0;
            nxt_state.phase       = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
         end
         PH_DATA: begin
            result.payload_valid  = 1'b1;
            result.payload_byte   = rx_byte;
            result.payload_index  = cur_state.count;
            nxt_state.running_xor = cur_state.running_xor ^ rx_byte;
            nxt_state.count       = count_inc;
            if (count_inc >= cur_state.length) begin
               nxt_state.phase = PH_SUM;
            end
         end
         PH_SUM: begin
            result.frame_done  = 1'b1;
            result.checksum_ok = (cur_state.running_xor == rx_byte);
            nxt_state.phase    = PH_HUNT;
         end
         default: begin
            // hunting, and any code that is not a legal phase
            nxt_state.phase = (rx_byte == START_BYTE) ? PH_TYPE : PH_HUNT;
         end
      endcase

      result.frame_kind     = nxt_state.kind;
      result.command_code   = nxt_state.command;
      result.payload_length = nxt_state.length;
   end

endmodule

`default_nettype wire

@@ hw/rtl/uart_frame_deframer_xor_core.sv @@
`default_nettype none

// serial frame deframer: takes one received byte per word and recognizes frames
// 0x02, type (0x80 reply / 0x81 command), command, length, payload[length], checksum,
// where the checksum is the xor of type, command, length and payload bytes. every
// input word gives exactly one result word: payload bytes come out with their index,
// the checksum byte raises frame_done with checksum_ok, and a bad type byte after
// 0x02 raises sync_lost. frame_kind, command_code and payload_length always show the
// current (or last) frame's header. throughput is one byte per clock while rsp_tready
// holds; each byte passes through the input register and then the result register,
// which holds the phase update and xor. the input register doubles as a skid stage, so
// one more byte is taken while a result waits on rsp_tready.
module uart_frame_deframer_xor_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // input words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] payload_valid, [8:1] payload_byte, [16:9] payload_index, [17] frame_done,
   // [18] checksum_ok, [26:19] command_code, [34:27] payload_length, [35] sync_lost,
   // [39:36] zero
   output logic [uffx_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic             rsp_tuser    // [0] frame_kind
);
   import uffx_pkg::*;

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;

   // parser state
   parse_state_type  state_ff, state_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   parse_result_type out_ff, out_in;

   parse_result_type step_result;
   parse_state_type  step_state;
   logic             advance;

   // the byte in the input register moves on when the result slot is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   uffx_step u_step (
      .cur_state (state_ff),
      .rx_byte   (in_byte_ff),
      .nxt_state (step_state),
      .result    (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end

      priority if (advance) begin
         state_in     = step_state;
         out_in       = step_result;
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         // result held while the sink stalls
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         state_ff.phase       <= PH_HUNT;
         state_ff.running_xor <= '0;
         state_ff.command     <= '0;
         state_ff.length      <= '0;
         state_ff.count       <= '0;
         state_ff.kind        <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.frame_kind;
   assign rsp_tdata  = {4'd0,
                        out_ff.sync_lost,
                        out_ff.payload_length,
                        out_ff.command_code,
                        out_ff.checksum_ok,
                        out_ff.frame_done,
                        out_ff.payload_index,
                        out_ff.payload_byte,
                        out_ff.payload_valid};

   // a result word is at most one of payload byte, frame end or sync loss
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones({out_ff.payload_valid, out_ff.frame_done,
                                 out_ff.sync_lost}) <= 1)
      else $error("result word carries more than one event");

   // checksum status only rides on the frame end
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.checksum_ok |-> out_ff.frame_done)
      else $error("checksum_ok without frame_done");

   // a frame end always returns the parser to hunting
   assert property (@(posedge clock) disable iff (reset)
      advance && step_result.frame_done |=> state_ff.phase == PH_HUNT)
      else $error("parser not hunting after checksum byte");

   // both stages full and the sink stalled: no more input is taken
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken while both stages are full");

endmodule

`default_nettype wire
